FILE: rtl/core/text_cursor_layout_unit_defines.svh
// ---------------------------------------------------------------------------
// Text cursor layout unit: assertion macros.
// Same-cycle and next-cycle property checks on clk with rst as the disable.
// ---------------------------------------------------------------------------
`ifndef TEXT_CURSOR_LAYOUT_UNIT_DEFINES_SVH
`define TEXT_CURSOR_LAYOUT_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define TCLU_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("text_cursor_layout_unit: same-cycle check failed");
`define TCLU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("text_cursor_layout_unit: next-cycle check failed");
`else
`define TCLU_ASSERT_SAME(label, ante, cons)
`define TCLU_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/core/tcl_pkg.sv
// ---------------------------------------------------------------------------
// Text cursor layout package
// Character classes, register indexes and the item passed from the front end
// to the layout engine.
// ---------------------------------------------------------------------------
package tcl_pkg;

  localparam logic [15:0] CH_TAB   = 16'h0009;
  localparam logic [15:0] CH_LF    = 16'h000A;
  localparam logic [15:0] CH_CR    = 16'h000D;
  localparam logic [15:0] CH_SPACE = 16'h0020;

  localparam logic [16:0] TAB_ADVANCE = 17'd4;

  typedef enum logic [2:0] {
    CLS_PRINT,
    CLS_SPACE,
    CLS_TAB,
    CLS_LF,
    CLS_CR,
    CLS_CTRL
  } cls_t;

  typedef enum logic [2:0] {
    CFG_ORIGIN_X,
    CFG_ORIGIN_Y,
    CFG_CELL_WIDTH,
    CFG_CELL_HEIGHT,
    CFG_BOX_WIDTH,
    CFG_BOX_HEIGHT,
    CFG_CUT_OFF,
    CFG_TEXT_COLOR
  } cfg_idx_t;

  typedef struct packed {
    cls_t        cls;
    logic        first;
    logic [15:0] entry;
  } item_t;

endpackage

FILE: rtl/core/tcl_front.sv
// ---------------------------------------------------------------------------
// Text cursor layout front end
// Accepts items, writes and reads the glyph table, classifies characters and
// hands one classified item at a time to the queue.
// ---------------------------------------------------------------------------
module tcl_front
  import tcl_pkg::*;
#(
  parameter int GLYPH_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic        first_of_string,
  input  logic [15:0] code_point,
  input  logic [7:0]  glyph_col,
  input  logic [7:0]  glyph_row,
  output logic        push_valid,
  input  logic        push_ready,
  output item_t       push_item
);

  localparam int IDX_W = $clog2(GLYPH_ENTRIES);

  logic [15:0]      mem [GLYPH_ENTRIES];
  logic [15:0]      rdata;
  logic             clearing;
  logic [IDX_W-1:0] clr_idx;
  logic             stage_valid;
  cls_t             stage_cls;
  logic             stage_first;
  logic             stage_in_table;
  logic             accept;
  logic             in_table;
  logic             push;
  cls_t             cls;
  logic [IDX_W-1:0] idx;

  assign in_table = ({1'b0, code_point} < 17'(GLYPH_ENTRIES));
  assign idx      = code_point[IDX_W-1:0];
  assign push     = stage_valid && push_ready;
  assign in_ready = !clearing && (!stage_valid || push_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    case (code_point)
      CH_TAB:   cls = CLS_TAB;
      CH_LF:    cls = CLS_LF;
      CH_CR:    cls = CLS_CR;
      CH_SPACE: cls = CLS_SPACE;
      default: begin
        if (code_point < CH_SPACE) begin
          cls = CLS_CTRL;
        end else begin
          cls = CLS_PRINT;
        end
      end
    endcase
  end

  // The table is swept to zero after reset, one entry per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == IDX_W'(GLYPH_ENTRIES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= '0;
    end else if (accept && req_type && in_table) begin
      mem[idx] <= {glyph_row, glyph_col};
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !req_type) begin
      rdata <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept && !req_type) begin
      stage_valid <= 1'b1;
    end else if (push) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !req_type) begin
      stage_cls      <= cls;
      stage_first    <= first_of_string;
      stage_in_table <= in_table;
    end
  end

  assign push_valid      = stage_valid;
  assign push_item.cls   = stage_cls;
  assign push_item.first = stage_first;
  assign push_item.entry = stage_in_table ? rdata : 16'h0000;

endmodule

FILE: rtl/core/tcl_queue.sv
// ---------------------------------------------------------------------------
// Text cursor layout queue
// Two-entry queue of classified items between the front end and the layout
// engine.
// ---------------------------------------------------------------------------
module tcl_queue
  import tcl_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: rtl/core/tcl_back.sv
// ---------------------------------------------------------------------------
// Text cursor layout engine
// Holds the registers and the cursor, steps the cursor for each item and
// drives the registered draw command.
// ---------------------------------------------------------------------------
module tcl_back
  import tcl_pkg::*;
#(
  parameter int GLYPH_SIZE = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  item_t       pop_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] draw_x,
  output logic [31:0] draw_y,
  output logic [15:0] src_x,
  output logic [15:0] src_y,
  output logic [23:0] color
);

  localparam logic [15:0] GSIZE = 16'(GLYPH_SIZE);

  logic [31:0] origin_x;
  logic [31:0] origin_y;
  logic [15:0] cell_width;
  logic [15:0] cell_height;
  logic [15:0] box_width;
  logic [15:0] box_height;
  logic        cut_off;
  logic [23:0] text_color;

  // Column and row are kept together with their pixel offsets, which are
  // rebuilt by one multiplication after a cell size changes.
  logic [15:0] col;
  logic [15:0] row;
  logic [31:0] col_px;
  logic [31:0] row_px;
  logic        stopped;
  logic        resync;

  logic [15:0] col_e;
  logic [15:0] row_e;
  logic [31:0] col_px_e;
  logic [31:0] row_px_e;
  logic        stop_e;
  logic [15:0] col_next;
  logic [15:0] row_next;
  logic [31:0] col_px_next;
  logic [31:0] row_px_next;
  logic        stopped_next;
  logic        draw;
  logic        advance;
  logic        is_tab;
  logic        row_inc;
  logic [16:0] col_sum;
  logic [17:0] inc_px;
  logic [33:0] px_sum;
  logic        pop;

  assign pop_ready = !resync && (!out_valid || out_ready);
  assign pop       = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x    <= 32'd0;
      origin_y    <= 32'd0;
      cell_width  <= 16'd8;
      cell_height <= 16'd8;
      box_width   <= 16'd0;
      box_height  <= 16'd0;
      cut_off     <= 1'b0;
      text_color  <= 24'hFFFFFF;
      resync      <= 1'b0;
    end else begin
      resync <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_ORIGIN_X:    origin_x <= cfg_data;
          CFG_ORIGIN_Y:    origin_y <= cfg_data;
          CFG_CELL_WIDTH: begin
            cell_width <= cfg_data[15:0];
            resync     <= 1'b1;
          end
          CFG_CELL_HEIGHT: begin
            cell_height <= cfg_data[15:0];
            resync      <= 1'b1;
          end
          CFG_BOX_WIDTH:   box_width <= cfg_data[15:0];
          CFG_BOX_HEIGHT:  box_height <= cfg_data[15:0];
          CFG_CUT_OFF:     cut_off <= cfg_data[0];
          CFG_TEXT_COLOR:  text_color <= cfg_data[23:0];
          default: ;
        endcase
      end
    end
  end

  assign col_e    = pop_item.first ? 16'd0 : col;
  assign row_e    = pop_item.first ? 16'd0 : row;
  assign col_px_e = pop_item.first ? 32'd0 : col_px;
  assign row_px_e = pop_item.first ? 32'd0 : row_px;
  assign stop_e   = pop_item.first ? 1'b0 : stopped;

  assign is_tab  = (pop_item.cls == CLS_TAB);
  assign col_sum = {1'b0, col_e} + (is_tab ? TAB_ADVANCE : 17'd1);
  assign inc_px  = is_tab ? {cell_width, 2'b00} : {2'b00, cell_width};
  assign px_sum  = {2'b00, col_px_e} + {16'd0, inc_px}
                 - (col_sum[16] ? {2'b00, cell_width, 16'd0} : 34'd0);

  always_comb begin
    col_next     = col_e;
    row_next     = row_e;
    col_px_next  = col_px_e;
    row_px_next  = row_px_e;
    stopped_next = stop_e;
    draw         = 1'b0;
    advance      = 1'b0;
    row_inc      = 1'b0;
    if (!stop_e) begin
      if ((box_height != 16'd0) && cut_off && (row_px_e > {16'd0, box_height})) begin
        stopped_next = 1'b1;
      end else if (!((pop_item.cls == CLS_SPACE) && (col_e == 16'd0))) begin
        case (pop_item.cls)
          CLS_TAB:   advance = 1'b1;
          CLS_LF: begin
            col_next    = 16'd0;
            col_px_next = 32'd0;
            row_inc     = 1'b1;
          end
          CLS_CR: begin
            col_next    = 16'd0;
            col_px_next = 32'd0;
          end
          CLS_PRINT, CLS_SPACE: begin
            advance = 1'b1;
            draw    = 1'b1;
          end
          default: ;
        endcase
        if (advance) begin
          col_next    = col_sum[15:0];
          col_px_next = px_sum[31:0];
        end
        if ((box_width != 16'd0) && (col_px_next >= {16'd0, box_width})) begin
          col_next    = 16'd0;
          col_px_next = 32'd0;
          row_inc     = 1'b1;
        end
        if (row_inc) begin
          row_next    = row_e + 16'd1;
          row_px_next = (row_e == 16'hFFFF) ? 32'd0 : row_px_e + {16'd0, cell_height};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= 16'd0;
      row     <= 16'd0;
      col_px  <= 32'd0;
      row_px  <= 32'd0;
      stopped <= 1'b0;
    end else if (resync) begin
      col_px <= {16'd0, col} * {16'd0, cell_width};
      row_px <= {16'd0, row} * {16'd0, cell_height};
    end else if (pop) begin
      col     <= col_next;
      row     <= row_next;
      col_px  <= col_px_next;
      row_px  <= row_px_next;
      stopped <= stopped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && draw) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && draw) begin
      draw_x <= origin_x + col_px_e;
      draw_y <= origin_y + row_px_e;
      src_x  <= {8'd0, pop_item.entry[7:0]} * GSIZE;
      src_y  <= {8'd0, pop_item.entry[15:8]} * GSIZE;
      color  <= text_color;
    end
  end

endmodule

FILE: rtl/core/text_cursor_layout_unit.sv
// ---------------------------------------------------------------------------
// Text cursor layout unit
// Lays out a stream of 16-bit code units in character cells. Input items are
// characters (req_type 0) or glyph table loads (req_type 1); each printable
// character or space yields one draw command on the output channel, except a
// space at column 0 and characters after the cut-off stops the layout.
// Registers are written through the cfg channel, which is always ready.
// Throughput is one item per cycle while the output is not stalled and the
// engine is not held. A drawn character passes through the front stage, which
// is loaded with the table read when it is accepted, the queue and the output
// register of the layout engine. After reset the glyph table is swept to zero,
// one entry per cycle, and no item is accepted until the sweep is done. A write
// of cell_width or cell_height holds the layout engine while it rebuilds its
// pixel offsets. When the receiver stalls, the output register holds its item
// and the queue and front stage fill before in_ready falls.
// ---------------------------------------------------------------------------
`include "text_cursor_layout_unit_defines.svh"

module text_cursor_layout_unit
  import tcl_pkg::*;
#(
  parameter int GLYPH_SIZE    = 8,
  parameter int GLYPH_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic        first_of_string,
  input  logic [15:0] code_point,
  input  logic [7:0]  glyph_col,
  input  logic [7:0]  glyph_row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] draw_x,
  output logic [31:0] draw_y,
  output logic [15:0] src_x,
  output logic [15:0] src_y,
  output logic [23:0] color,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic  stage_valid;
  logic  q_push_ready;
  item_t q_push_item;
  logic  q_pop_valid;
  logic  q_pop_ready;
  item_t q_pop_item;
  logic  q_pop;
  logic  resize_write;

  assign cfg_ready    = 1'b1;
  assign q_pop        = q_pop_valid && q_pop_ready;
  assign resize_write = cfg_valid && cfg_ready &&
                        (cfg_index inside {CFG_CELL_WIDTH, CFG_CELL_HEIGHT});

  tcl_front #(
    .GLYPH_ENTRIES(GLYPH_ENTRIES)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .first_of_string(first_of_string),
    .code_point     (code_point),
    .glyph_col      (glyph_col),
    .glyph_row      (glyph_row),
    .push_valid     (stage_valid),
    .push_ready     (q_push_ready),
    .push_item      (q_push_item)
  );

  tcl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(stage_valid),
    .push_ready(q_push_ready),
    .push_item (q_push_item),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_item  (q_pop_item)
  );

  tcl_back #(
    .GLYPH_SIZE(GLYPH_SIZE)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pop_valid(q_pop_valid),
    .pop_ready(q_pop_ready),
    .pop_item (q_pop_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .draw_x   (draw_x),
    .draw_y   (draw_y),
    .src_x    (src_x),
    .src_y    (src_y),
    .color    (color)
  );

  `TCLU_ASSERT_NEXT(a_char_enters_front, in_valid && in_ready && !req_type, stage_valid)
  `TCLU_ASSERT_NEXT(a_resize_holds_engine, resize_write, !q_pop)
  `TCLU_ASSERT_SAME(a_output_from_queue, $rose(out_valid), $past(q_pop))

endmodule
